### hdl/jecc_pkg.sv
`default_nettype none

package jecc_pkg;

  localparam int DEFAULT_NUM_AXES = 8;

  localparam int KIND_W = 7;
  localparam int CTRL_W = 7;
  localparam int CHAN_W = 8;
  localparam int VAL_W  = 16;

  localparam logic [KIND_W-1:0] KIND_BUTTON = 7'd1;
  localparam logic [KIND_W-1:0] KIND_AXIS   = 7'd2;

  localparam logic [1:0] CFG_AXIS0_CTRL = 2'd0;
  localparam logic [1:0] CFG_AXIS1_CTRL = 2'd1;
  localparam logic [1:0] CFG_AXIS2_CTRL = 2'd2;
  localparam logic [1:0] CFG_AXIS3_CTRL = 2'd3;

  localparam logic [CTRL_W-1:0] AXIS0_CTRL_RST = 7'd10;
  localparam logic [CTRL_W-1:0] AXIS1_CTRL_RST = 7'd11;
  localparam logic [CTRL_W-1:0] AXIS2_CTRL_RST = 7'd12;
  localparam logic [CTRL_W-1:0] AXIS3_CTRL_RST = 7'd13;

  localparam logic [7:0] HIGH_AXIS_CTRL_BASE = 8'd10;
  localparam logic [CHAN_W-1:0] CHAN_RST = 8'd1;

  typedef struct packed {
    logic              seen;
    logic [CTRL_W-1:0] value;
  } axis_entry_t;

endpackage

`default_nettype wire

### hdl/joystick_event_to_midi_cc.sv
// An accepted request is held in stage one, then registered into the output stage that drives out_tvalid.
// Throughput: one request per cycle, with out_tready held high.
// The per-axis store is read at accept and, for an emitted axis value, written back as the request leaves stage one.
// Reset (rst_n low, synchronous) clears both stages, sets the channel to one,
// restores the controller registers and marks every stored axis value as zero.
`default_nettype none

module joystick_event_to_midi_cc #(
  parameter int NUM_AXES = jecc_pkg::DEFAULT_NUM_AXES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // event_number [7:0], event_value [23:8]
  input  wire logic [23:0] in_tdata,
  // event_kind [7:0]
  input  wire logic [7:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // midi_channel [7:0], controller_number [14:8], controller_value [21:15]
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import jecc_pkg::*;

  localparam int AXIS_AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [8:0] NUM_AXES_W = 9'(NUM_AXES);

  logic [CTRL_W-1:0] ctrl_r [4];
  logic [CHAN_W-1:0] chan_r;
  logic [CHAN_W-1:0] chan_nxt;

  logic                    s1_valid_r;
  logic [KIND_W-1:0]       s1_kind_r;
  logic [7:0]              s1_number_r;
  logic signed [VAL_W-1:0] s1_value_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic [CTRL_W-1:0] out_ctrl_r;
  logic [CTRL_W-1:0] out_value_r;

  logic              in_acc;
  logic              advance;
  logic              is_button;
  logic              is_axis;
  logic              in_range;
  logic              emit;
  logic [CTRL_W-1:0] scaled;
  logic [CTRL_W-1:0] last_val;
  logic [CTRL_W-1:0] ctrl_sel;
  axis_entry_t       rd_entry;
  axis_entry_t       wr_entry;
  logic              wr_en;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  jecc_axis_store #(
    .NUM_AXES (NUM_AXES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_tdata[AXIS_AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (s1_number_r[AXIS_AW-1:0]),
    .wr_data (wr_entry)
  );

  jecc_scale u_scale (
    .value  (s1_value_r),
    .scaled (scaled)
  );

  always_comb begin
    is_button = (s1_kind_r == KIND_BUTTON);
    is_axis   = (s1_kind_r == KIND_AXIS);
    in_range  = ({1'b0, s1_number_r} < NUM_AXES_W);
    last_val  = rd_entry.seen ? rd_entry.value : '0;
    emit      = is_axis && in_range && (scaled != last_val);
    wr_en     = advance && emit;
    wr_entry  = '{seen: 1'b1, value: scaled};
    if (s1_number_r < 8'd4) begin
      ctrl_sel = ctrl_r[s1_number_r[1:0]];
    end else begin
      ctrl_sel = CTRL_W'(s1_number_r + HIGH_AXIS_CTRL_BASE);
    end
    chan_nxt = chan_r;
    if (advance && is_button && (s1_value_r != '0)) begin
      chan_nxt = s1_number_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r[CFG_AXIS0_CTRL] <= AXIS0_CTRL_RST;
      ctrl_r[CFG_AXIS1_CTRL] <= AXIS1_CTRL_RST;
      ctrl_r[CFG_AXIS2_CTRL] <= AXIS2_CTRL_RST;
      ctrl_r[CFG_AXIS3_CTRL] <= AXIS3_CTRL_RST;
      chan_r                 <= CHAN_RST;
    end else begin
      if (cfg_wr_en) begin
        ctrl_r[cfg_index] <= cfg_data;
      end
      chan_r <= chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_tuser[KIND_W-1:0];
      s1_number_r <= in_tdata[7:0];
      s1_value_r  <= in_tdata[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_chan_r  <= chan_r;
      out_ctrl_r  <= ctrl_sel;
      out_value_r <= scaled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_value_r, out_ctrl_r, out_chan_r};

endmodule

`default_nettype wire

### hdl/jecc_scale.sv
`default_nettype none

module jecc_scale (
  input  wire logic signed [jecc_pkg::VAL_W-1:0]  value,
  output logic             [jecc_pkg::CTRL_W-1:0] scaled
);
  import jecc_pkg::*;

  logic [VAL_W-1:0] offs;
  logic [VAL_W-1:0] shifted;
  logic [22:0]      prod;
  logic [23:0]      sum;

  // The offset value is the position plus 32768; the most negative input clamps to zero.
  always_comb begin
    offs    = {~value[VAL_W-1], value[VAL_W-2:0]};
    shifted = offs - 16'd1;
    prod    = ({shifted, 7'd0}) - 23'(shifted);
    sum     = 24'(prod) + 24'(prod[22:16]) + 24'd1;
    if (offs == '0) begin
      scaled = '0;
    end else begin
      scaled = sum[22:16];
    end
  end

endmodule

`default_nettype wire

### hdl/jecc_axis_store.sv
`default_nettype none

module jecc_axis_store #(
  parameter int NUM_AXES = jecc_pkg::DEFAULT_NUM_AXES
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     rd_en,
  input  wire logic [((NUM_AXES > 1) ? $clog2(NUM_AXES) : 1)-1:0] rd_addr,
  output jecc_pkg::axis_entry_t                         rd_data,
  input  wire logic                                     wr_en,
  input  wire logic [((NUM_AXES > 1) ? $clog2(NUM_AXES) : 1)-1:0] wr_addr,
  input  wire jecc_pkg::axis_entry_t                    wr_data
);
  import jecc_pkg::*;

  logic [CTRL_W-1:0] mem_r [NUM_AXES];
  logic [NUM_AXES-1:0] vld_r;
  axis_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // A write to the entry being read in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= '{seen: vld_r[rd_addr], value: mem_r[rd_addr]};
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
